// ----- sv/glqe_pkg.sv -----
// ---------------------------------------------------------------------------
// glqe_pkg
// shared types, constants and reset values for the glyph quad layout emitter
// ---------------------------------------------------------------------------
package glqe_pkg;

    localparam int FIX_W      = 48;   // Q16.32 word
    localparam int DEPTH_W    = 47;   // depth as delivered
    localparam int CODE_W     = 8;
    localparam int STRIDE_W   = 9;
    localparam int WRAP_W     = 8;
    localparam int LINE_W     = 9;
    localparam int CORNER_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_CHARS_DEFAULT = 256;

    localparam logic [CODE_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [DEPTH_W-1:0] DEPTH_STEP   = 47'd429497;  // 0.0001 in Q16.32
    localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd5;

    // reset values of the configuration registers
    localparam logic [DEPTH_W-1:0]  RST_CELL_WIDTH  = 47'd268435456;
    localparam logic [DEPTH_W-1:0]  RST_CELL_HEIGHT = 47'd268435456;
    localparam logic [STRIDE_W-1:0] RST_STRIDE      = 9'd16;
    localparam logic [WRAP_W-1:0]   RST_WRAP        = 8'd0;
    localparam logic [FIX_W-1:0]    RST_X_OFFSET    = 48'd0;
    localparam logic [FIX_W-1:0]    RST_Y_OFFSET    = 48'd0;
    localparam logic [FIX_W-1:0]    RST_CROWDING    = 48'd2576980378;

    // reset values of the derived geometry
    localparam logic [FIX_W-1:0] RST_QUAD_W  = 48'({1'b0, RST_CELL_WIDTH} * 48'd20);
    localparam logic [FIX_W-1:0] RST_QUAD_H  = 48'(48'd0 - 48'({1'b0, RST_CELL_HEIGHT} * 48'd20));
    localparam logic [FIX_W-1:0] RST_PEN_ADV = 48'(RST_QUAD_W - RST_CROWDING);
    localparam logic [FIX_W-1:0] RST_U_FAR   = 48'(RST_X_OFFSET + {1'b0, RST_CELL_WIDTH});
    localparam logic [FIX_W-1:0] RST_V_FAR   = 48'(RST_Y_OFFSET + {1'b0, RST_CELL_HEIGHT});

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELL_WIDTH  = 3'd0,
        REG_CELL_HEIGHT = 3'd1,
        REG_STRIDE      = 3'd2,
        REG_WRAP        = 3'd3,
        REG_X_OFFSET    = 3'd4,
        REG_Y_OFFSET    = 3'd5,
        REG_CROWDING    = 3'd6
    } glqe_reg_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_PUSH
    } glqe_front_state_t;

    // configuration as seen by front and back
    typedef struct packed {
        logic [DEPTH_W-1:0]  cell_width;
        logic [DEPTH_W-1:0]  cell_height;
        logic [STRIDE_W-1:0] atlas_stride;
        logic [WRAP_W-1:0]   wrap_limit;
        logic [FIX_W-1:0]    x_offset;
        logic [FIX_W-1:0]    y_offset;
    } glqe_cfg_t;

    // geometry derived from the configuration
    typedef struct packed {
        logic [FIX_W-1:0] quad_w;   // 20 * cell_width
        logic [FIX_W-1:0] quad_h;   // -20 * cell_height
        logic [FIX_W-1:0] pen_adv;  // quad_w - crowding
        logic [FIX_W-1:0] u_far;    // x_offset + cell_width
        logic [FIX_W-1:0] v_far;    // y_offset + cell_height
    } glqe_geom_t;

    // one classified character waiting for the emitter
    typedef struct packed {
        logic [CODE_W-1:0]  col;
        logic [CODE_W-1:0]  row;
        logic [FIX_W-1:0]   x0;
        logic [FIX_W-1:0]   y0;
        logic [DEPTH_W-1:0] z;
    } glqe_entry_t;

endpackage

// ----- sv/glyph_quad_layout_emitter.sv -----
// ---------------------------------------------------------------------------
// glyph_quad_layout_emitter
// lays out a character stream as textured quads, six vertices per character
// ---------------------------------------------------------------------------
//
//  channel   direction  beat contents
//  s_*       in         tdata[7:0] char_code, tuser first (restart layout)
//  m_*       out        tdata x, y, z, u, v, corner; tlast on sixth vertex
//  cfg_*     in         write enable, register index 0..6, 48-bit data
//
// the front takes one character at a time: accept beat, the radix-4
// code/stride divider (pen update in its first step), queue write; the
// back emits one vertex per cycle while m_tready is high. a dropped
// character (text full) frees the input after the first divider step.
// reset restores the register defaults and puts the pen at the origin.
// a stalled output holds the vertex; the two-entry queue plus the product
// stage let the front keep accepting while the back waits.
//
module glyph_quad_layout_emitter #(
    parameter int MAX_CHARS = glqe_pkg::MAX_CHARS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // character input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] char_code
    input  logic                           s_tuser,   // [0] first
    // vertex output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [47:0] pos_x, [95:48] pos_y, [142:96] pos_z, [190:143] tex_u,
    // [238:191] tex_v, [241:239] corner, [247:242] zero
    output logic [247:0]                   m_tdata,
    output logic                           m_tlast,   // last_vertex
    // configuration writes
    input  logic                           cfg_we,
    input  logic [glqe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [glqe_pkg::FIX_W-1:0]     cfg_data
);

    // configuration registers
    glqe_pkg::glqe_cfg_t           cfg_reg;
    logic [glqe_pkg::FIX_W-1:0]    crowding_reg;
    // derived geometry, registered from the configuration registers
    glqe_pkg::glqe_geom_t          geom_reg, geom_next;
    logic [glqe_pkg::FIX_W-1:0]    cw_ext, ch_ext, w20, h20;

    // front to queue
    logic                          push, push_ready;
    glqe_pkg::glqe_entry_t         push_entry;
    // queue to back
    logic                          q_valid, q_pop;
    glqe_pkg::glqe_entry_t         q_entry;

    logic [glqe_pkg::FIX_W-1:0]    pos_x, pos_y, tex_u, tex_v;
    logic [glqe_pkg::DEPTH_W-1:0]  pos_z;
    logic [glqe_pkg::CORNER_W-1:0] corner;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_width   <= glqe_pkg::RST_CELL_WIDTH;
            cfg_reg.cell_height  <= glqe_pkg::RST_CELL_HEIGHT;
            cfg_reg.atlas_stride <= glqe_pkg::RST_STRIDE;
            cfg_reg.wrap_limit   <= glqe_pkg::RST_WRAP;
            cfg_reg.x_offset     <= glqe_pkg::RST_X_OFFSET;
            cfg_reg.y_offset     <= glqe_pkg::RST_Y_OFFSET;
            crowding_reg         <= glqe_pkg::RST_CROWDING;
        end
        else if (cfg_we)
        begin
            // values are cut to each register's width; unknown indexes are ignored
            case (cfg_index)
                glqe_pkg::REG_CELL_WIDTH:  cfg_reg.cell_width   <= cfg_data[46:0];
                glqe_pkg::REG_CELL_HEIGHT: cfg_reg.cell_height  <= cfg_data[46:0];
                glqe_pkg::REG_STRIDE:      cfg_reg.atlas_stride <= cfg_data[8:0];
                glqe_pkg::REG_WRAP:        cfg_reg.wrap_limit   <= cfg_data[7:0];
                glqe_pkg::REG_X_OFFSET:    cfg_reg.x_offset     <= cfg_data;
                glqe_pkg::REG_Y_OFFSET:    cfg_reg.y_offset     <= cfg_data;
                glqe_pkg::REG_CROWDING:    crowding_reg         <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // quad size is 20 cells: x*16 + x*4, all mod 2^48
    always_comb
    begin
        cw_ext            = {1'b0, cfg_reg.cell_width};
        ch_ext            = {1'b0, cfg_reg.cell_height};
        w20               = 48'((cw_ext << 4) + (cw_ext << 2));
        h20               = 48'((ch_ext << 4) + (ch_ext << 2));
        geom_next.quad_w  = w20;
        geom_next.quad_h  = 48'(48'd0 - h20);
        geom_next.pen_adv = 48'(w20 - crowding_reg);
        geom_next.u_far   = 48'(cfg_reg.x_offset + cw_ext);
        geom_next.v_far   = 48'(cfg_reg.y_offset + ch_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.quad_w  <= glqe_pkg::RST_QUAD_W;
            geom_reg.quad_h  <= glqe_pkg::RST_QUAD_H;
            geom_reg.pen_adv <= glqe_pkg::RST_PEN_ADV;
            geom_reg.u_far   <= glqe_pkg::RST_U_FAR;
            geom_reg.v_far   <= glqe_pkg::RST_V_FAR;
        end
        else
        begin
            geom_reg <= geom_next;
        end
    end

    // front: classify the code and advance the pen
    glqe_front #(
        .MAX_CHARS (MAX_CHARS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_code    (s_tdata),
        .in_first   (s_tuser),
        .cfg        (cfg_reg),
        .geom       (geom_reg),
        .push       (push),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    glqe_fifo #(
        .DEPTH (glqe_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_ready (push_ready),
        .wr_entry (push_entry),
        .rd_valid (q_valid),
        .rd_en    (q_pop),
        .rd_entry (q_entry)
    );

    // back: atlas products, then six vertex beats per quad
    glqe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_entry     (q_entry),
        .cfg         (cfg_reg),
        .geom        (geom_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .tex_u       (tex_u),
        .tex_v       (tex_v),
        .corner      (corner),
        .last_vertex (m_tlast)
    );

    assign m_tdata = {6'd0, corner, tex_v, tex_u, pos_z, pos_y, pos_x};

endmodule

// ----- sv/glqe_front.sv -----
// ---------------------------------------------------------------------------
// glqe_front
// accepts characters, splits the code into atlas column and row, keeps the pen
// ---------------------------------------------------------------------------
module glqe_front #(
    parameter int MAX_CHARS = glqe_pkg::MAX_CHARS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [glqe_pkg::CODE_W-1:0] in_code,
    input  logic                        in_first,
    input  glqe_pkg::glqe_cfg_t         cfg,
    input  glqe_pkg::glqe_geom_t        geom,
    output logic                        push,
    input  logic                        push_ready,
    output glqe_pkg::glqe_entry_t       push_entry
);

    localparam int CNT_W = $clog2(MAX_CHARS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHARS);

    glqe_pkg::glqe_front_state_t state_reg, state_next;
    logic [1:0]                      cnt_reg, cnt_next;
    logic [glqe_pkg::CODE_W-1:0]     code_reg, code_next;
    logic                            first_reg, first_next;
    logic [8:0]                      rem_reg, rem_next;
    logic [glqe_pkg::CODE_W-1:0]     quo_reg, quo_next;
    logic [9:0]                      dvs_reg, dvs_next;
    logic [glqe_pkg::FIX_W-1:0]      pen_x_reg, pen_x_next;
    logic [glqe_pkg::FIX_W-1:0]      pen_y_reg, pen_y_next;
    logic [glqe_pkg::DEPTH_W-1:0]    depth_reg, depth_next;
    logic [glqe_pkg::LINE_W-1:0]     line_reg, line_next;
    logic [CNT_W-1:0]                placed_reg, placed_next;
    logic [glqe_pkg::FIX_W-1:0]      x0_reg, x0_next;
    logic [glqe_pkg::FIX_W-1:0]      y0_reg, y0_next;
    logic [glqe_pkg::DEPTH_W-1:0]    z_reg, z_next;

    // radix-4 divider datapath
    logic [9:0]                      t_a, t_b;
    logic                            ge_a, ge_b;
    logic [8:0]                      r_a, r_b;
    logic [glqe_pkg::CODE_W-1:0]     q_a, q_b;

    // layout state after an optional restart
    logic [glqe_pkg::FIX_W-1:0]      px, py;
    logic [glqe_pkg::DEPTH_W-1:0]    pz;
    logic [glqe_pkg::LINE_W-1:0]     pl, pl_inc;
    logic [CNT_W-1:0]                pc;
    logic                            wrap_on, line_break, drop;

    assign in_ready   = (state_reg == glqe_pkg::FS_IDLE);
    assign push_entry = '{col: rem_reg[glqe_pkg::CODE_W-1:0], row: quo_reg,
                          x0: x0_reg, y0: y0_reg, z: z_reg};

    always_comb
    begin
        // two restoring steps per cycle
        t_a  = {rem_reg, quo_reg[7]};
        ge_a = (t_a >= dvs_reg);
        r_a  = ge_a ? 9'(t_a - dvs_reg) : t_a[8:0];
        q_a  = {quo_reg[6:0], ge_a};
        t_b  = {r_a, q_a[7]};
        ge_b = (t_b >= dvs_reg);
        r_b  = ge_b ? 9'(t_b - dvs_reg) : t_b[8:0];
        q_b  = {q_a[6:0], ge_b};

        px = first_reg ? '0 : pen_x_reg;
        py = first_reg ? '0 : pen_y_reg;
        pz = first_reg ? '0 : depth_reg;
        pl = first_reg ? '0 : line_reg;
        pc = first_reg ? '0 : placed_reg;

        wrap_on    = (cfg.wrap_limit != '0);
        pl_inc     = wrap_on ? 9'(pl + 9'd1) : pl;
        line_break = (code_reg == glqe_pkg::NEWLINE_CODE) ||
                     (wrap_on && (pl_inc > {1'b0, cfg.wrap_limit}));
        drop       = (pc >= MAX_CNT);

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        code_next   = code_reg;
        first_next  = first_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        pen_x_next  = pen_x_reg;
        pen_y_next  = pen_y_reg;
        depth_next  = depth_reg;
        line_next   = line_reg;
        placed_next = placed_reg;
        x0_next     = x0_reg;
        y0_next     = y0_reg;
        z_next      = z_reg;
        push        = 1'b0;

        case (state_reg)
            glqe_pkg::FS_IDLE:
            begin
                if (in_valid)
                begin
                    code_next  = in_code;
                    first_next = in_first;
                    quo_next   = in_code;
                    rem_next   = '0;
                    // stride 0 acts as 512: quotient 0, remainder the code
                    dvs_next   = (cfg.atlas_stride == '0) ? 10'd512
                                                          : {1'b0, cfg.atlas_stride};
                    cnt_next   = '0;
                    state_next = glqe_pkg::FS_DIV;
                end
            end
            glqe_pkg::FS_DIV:
            begin
                rem_next = r_b;
                quo_next = q_b;
                cnt_next = 2'(cnt_reg + 2'd1);
                if (cnt_reg == 2'd0)
                begin
                    // restart takes effect even when the character is dropped
                    pen_x_next  = px;
                    pen_y_next  = py;
                    depth_next  = pz;
                    line_next   = pl;
                    placed_next = pc;
                    if (drop)
                    begin
                        state_next = glqe_pkg::FS_IDLE;
                    end
                    else
                    begin
                        x0_next     = px;
                        y0_next     = py;
                        z_next      = pz;
                        depth_next  = 47'(pz + glqe_pkg::DEPTH_STEP);
                        placed_next = CNT_W'(pc + CNT_W'(1));
                        if (line_break)
                        begin
                            pen_x_next = '0;
                            pen_y_next = 48'(py + geom.quad_h);
                            line_next  = '0;
                        end
                        else
                        begin
                            pen_x_next = 48'(px + geom.pen_adv);
                            line_next  = pl_inc;
                        end
                    end
                end
                if (cnt_reg == 2'd3)
                begin
                    state_next = glqe_pkg::FS_PUSH;
                end
            end
            glqe_pkg::FS_PUSH:
            begin
                push = 1'b1;
                if (push_ready)
                begin
                    state_next = glqe_pkg::FS_IDLE;
                end
            end
            default:
            begin
                state_next = glqe_pkg::FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= glqe_pkg::FS_IDLE;
            cnt_reg    <= '0;
            pen_x_reg  <= '0;
            pen_y_reg  <= '0;
            depth_reg  <= '0;
            line_reg   <= '0;
            placed_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pen_x_reg  <= pen_x_next;
            pen_y_reg  <= pen_y_next;
            depth_reg  <= depth_next;
            line_reg   <= line_next;
            placed_reg <= placed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        first_reg <= first_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        x0_reg    <= x0_next;
        y0_reg    <= y0_next;
        z_reg     <= z_next;
    end

endmodule

// ----- sv/glqe_fifo.sv -----
// ---------------------------------------------------------------------------
// glqe_fifo
// short queue of classified characters between front and back
// ---------------------------------------------------------------------------
module glqe_fifo #(
    parameter int DEPTH = glqe_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    output logic                  wr_ready,
    input  glqe_pkg::glqe_entry_t wr_entry,
    output logic                  rd_valid,
    input  logic                  rd_en,
    output glqe_pkg::glqe_entry_t rd_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    glqe_pkg::glqe_entry_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = mem[rd_ptr_reg];
    assign do_wr    = wr_en && wr_ready;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + PTR_W'(1));
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + PTR_W'(1));
        end
        count_next = CNT_W'(count_reg + CNT_W'(do_wr) - CNT_W'(do_rd));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ----- sv/glqe_back.sv -----
// ---------------------------------------------------------------------------
// glqe_back
// scales atlas cells and emits the six vertices of each quad
// ---------------------------------------------------------------------------
module glqe_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  glqe_pkg::glqe_entry_t         q_entry,
    input  glqe_pkg::glqe_cfg_t           cfg,
    input  glqe_pkg::glqe_geom_t          geom,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [glqe_pkg::FIX_W-1:0]    pos_x,
    output logic [glqe_pkg::FIX_W-1:0]    pos_y,
    output logic [glqe_pkg::DEPTH_W-1:0]  pos_z,
    output logic [glqe_pkg::FIX_W-1:0]    tex_u,
    output logic [glqe_pkg::FIX_W-1:0]    tex_v,
    output logic [glqe_pkg::CORNER_W-1:0] corner,
    output logic                          last_vertex
);

    // product stage
    logic                         p_valid_reg, p_valid_next;
    logic [glqe_pkg::FIX_W-1:0]   mul_u_reg, mul_v_reg;
    logic [glqe_pkg::FIX_W-1:0]   p_x0_reg, p_y0_reg;
    logic [glqe_pkg::DEPTH_W-1:0] p_z_reg;

    // vertex stage
    logic                          e_valid_reg, e_valid_next;
    logic [glqe_pkg::CORNER_W-1:0] corner_reg, corner_next;
    logic [glqe_pkg::FIX_W-1:0]    x0_reg, x1_reg, y0_reg, y1_reg;
    logic [glqe_pkg::FIX_W-1:0]    u0_reg, u1_reg, v0_reg, v1_reg;
    logic [glqe_pkg::DEPTH_W-1:0]  z_reg;

    logic e_load, beat, quad_done, right, down;

    assign beat      = e_valid_reg && out_ready;
    assign quad_done = beat && (corner_reg == glqe_pkg::LAST_CORNER);
    assign e_load    = p_valid_reg && (!e_valid_reg || quad_done);
    assign q_pop     = q_valid && (!p_valid_reg || e_load);

    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (q_pop)
        begin
            p_valid_next = 1'b1;
        end
        else if (e_load)
        begin
            p_valid_next = 1'b0;
        end

        e_valid_next = e_valid_reg;
        corner_next  = corner_reg;
        if (e_load)
        begin
            e_valid_next = 1'b1;
            corner_next  = '0;
        end
        else if (quad_done)
        begin
            e_valid_next = 1'b0;
        end
        else if (beat)
        begin
            corner_next = 3'(corner_reg + 3'd1);
        end
    end

    // corner order: 0 near/top, 1 far/top, 2 far/bottom, 3 near/top, 4 far/bottom, 5 near/bottom
    always_comb
    begin
        case (corner_reg)
            3'd0:    begin right = 1'b0; down = 1'b0; end
            3'd1:    begin right = 1'b1; down = 1'b0; end
            3'd2:    begin right = 1'b1; down = 1'b1; end
            3'd3:    begin right = 1'b0; down = 1'b0; end
            3'd4:    begin right = 1'b1; down = 1'b1; end
            3'd5:    begin right = 1'b0; down = 1'b1; end
            default: begin right = 1'b0; down = 1'b0; end
        endcase
    end

    assign out_valid   = e_valid_reg;
    assign pos_x       = right ? x1_reg : x0_reg;
    assign pos_y       = down ? y1_reg : y0_reg;
    assign pos_z       = z_reg;
    assign tex_u       = right ? u1_reg : u0_reg;
    assign tex_v       = down ? v1_reg : v0_reg;
    assign corner      = corner_reg;
    assign last_vertex = (corner_reg == glqe_pkg::LAST_CORNER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            corner_reg  <= '0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            e_valid_reg <= e_valid_next;
            corner_reg  <= corner_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            mul_u_reg <= 48'({40'd0, q_entry.col} * {1'b0, cfg.cell_width});
            mul_v_reg <= 48'({40'd0, q_entry.row} * {1'b0, cfg.cell_height});
            p_x0_reg  <= q_entry.x0;
            p_y0_reg  <= q_entry.y0;
            p_z_reg   <= q_entry.z;
        end
        if (e_load)
        begin
            x0_reg <= p_x0_reg;
            x1_reg <= 48'(p_x0_reg + geom.quad_w);
            y0_reg <= p_y0_reg;
            y1_reg <= 48'(p_y0_reg + geom.quad_h);
            z_reg  <= p_z_reg;
            u0_reg <= 48'(mul_u_reg + cfg.x_offset);
            u1_reg <= 48'(mul_u_reg + geom.u_far);
            v0_reg <= 48'(mul_v_reg + cfg.y_offset);
            v1_reg <= 48'(mul_v_reg + geom.v_far);
        end
    end

endmodule
